// ----- rtl/core/stbs_pkg.sv -----
package stbs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [7:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] search_key;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [7:0] found_index;
    } t_out_item;

    typedef struct packed {
        logic               is_search;
        logic [IDX_W-1:0]   index;
        logic signed [31:0] data;
    } t_cmd;

endpackage

// ----- rtl/core/stbs_front.sv -----
module stbs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stbs_pkg::t_in_item i_in_item,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output stbs_pkg::t_cmd     o_push_cmd
);

    logic           r_valid;
    stbs_pkg::t_cmd r_cmd;
    stbs_pkg::t_cmd n_cmd;

    assign o_in_ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

    always_comb begin
        n_cmd.is_search = (i_in_item.mode == stbs_pkg::MODE_SEARCH);
        n_cmd.index     = i_in_item.entry_index[stbs_pkg::IDX_W-1:0];
        n_cmd.data      = (i_in_item.mode == stbs_pkg::MODE_SEARCH) ? i_in_item.search_key
                                                                     : i_in_item.entry_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
            r_cmd   <= n_cmd;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ----- rtl/core/stbs_queue.sv -----
module stbs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  stbs_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output stbs_pkg::t_cmd o_pop_cmd
);

    stbs_pkg::t_cmd                    r_mem [stbs_pkg::QUEUE_DEPTH];
    logic [stbs_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [stbs_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [stbs_pkg::QCNT_W-1:0]       r_count;
    logic                              push;
    logic                              pop;

    assign o_push_ready = (r_count != stbs_pkg::QCNT_W'(stbs_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/stbs_back.sv -----
module stbs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [stbs_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          i_cmd_valid,
    input  stbs_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output stbs_pkg::t_out_item           o_out_item
);

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } t_state;

    t_state                         r_state;
    logic [stbs_pkg::CNT_W-1:0]     r_count;
    logic [stbs_pkg::CNT_W-1:0]     r_lo;
    logic [stbs_pkg::CNT_W-1:0]     r_hi;
    logic [stbs_pkg::IDX_W-1:0]     r_mid;
    logic signed [31:0]             r_key;
    logic signed [31:0]             r_rd_data;
    logic signed [31:0]             r_mem [stbs_pkg::TABLE_DEPTH];
    logic                           r_out_valid;
    stbs_pkg::t_out_item            r_out_item;

    logic                           out_free;
    logic                           start_search;
    logic                           do_write;
    logic                           key_eq;
    logic                           key_lt;
    logic [stbs_pkg::CNT_W-1:0]     cand_lo;
    logic [stbs_pkg::CNT_W-1:0]     cand_hi;
    logic [stbs_pkg::CNT_W:0]       mid_sum;
    logic [stbs_pkg::IDX_W-1:0]     next_mid;
    logic                           range_empty;
    logic                           result_set;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign out_free     = !r_out_valid || i_out_ready;
    assign start_search = (r_state == S_IDLE) && i_cmd_valid && i_cmd.is_search && out_free;
    assign do_write     = (r_state == S_IDLE) && i_cmd_valid && !i_cmd.is_search;
    assign o_cmd_pop    = start_search || do_write;

    assign key_eq = (r_key == r_rd_data);
    assign key_lt = (r_key < r_rd_data);

    assign result_set = (r_state == S_IDLE) ? (start_search && range_empty)
                                            : (key_eq || range_empty);

    always_comb begin
        if (r_state == S_IDLE) begin
            cand_lo = '0;
            cand_hi = r_count;
        end else if (key_lt) begin
            cand_lo = r_lo;
            cand_hi = {1'b0, r_mid};
        end else begin
            cand_lo = {1'b0, r_mid} + 1'b1;
            cand_hi = r_hi;
        end
        mid_sum     = {1'b0, cand_lo} + {1'b0, cand_hi};
        next_mid    = mid_sum[stbs_pkg::IDX_W:1];
        range_empty = (cand_lo >= cand_hi);
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[i_cmd.index] <= i_cmd.data;
        end
        r_rd_data <= r_mem[next_mid];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= result_set || (r_out_valid && !i_out_ready);
            if (i_cfg_valid) begin
                r_count <= (i_cfg_data > stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH))
                           ? stbs_pkg::CNT_W'(stbs_pkg::TABLE_DEPTH) : i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (start_search) begin
                        r_key <= i_cmd.data;
                        if (range_empty) begin
                            r_out_item.found       <= 1'b0;
                            r_out_item.found_index <= '0;
                        end else begin
                            r_lo    <= cand_lo;
                            r_hi    <= cand_hi;
                            r_mid   <= next_mid;
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    if (key_eq) begin
                        r_out_item.found       <= 1'b1;
                        r_out_item.found_index <= 8'(r_mid);
                        r_state                <= S_IDLE;
                    end else if (range_empty) begin
                        r_out_item.found       <= 1'b0;
                        r_out_item.found_index <= '0;
                        r_state                <= S_IDLE;
                    end else begin
                        r_lo  <= cand_lo;
                        r_hi  <= cand_hi;
                        r_mid <= next_mid;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/sorted_table_binary_search_unit.sv -----
// Channel   Signals                              Payload
// in        i_in_valid / o_in_ready              i_in_item  (stbs_pkg::t_in_item)
// out       o_out_valid / i_out_ready            o_out_item (stbs_pkg::t_out_item)
// cfg       i_cfg_valid / o_cfg_ready            i_cfg_data (entry_count, 9 bits)
//
// A table write is done by the back end in its idle state and gives no result.
// A search makes one table probe per S_PROBE step, up to 9 probes for
// 256 entries; each probe compares the key with a registered table read.
// Front register and a 4-deep command queue keep taking transactions while the
// back end searches or a result waits on i_out_ready, as long as they have room.
// Reset clears control state and entry_count; table contents stay undefined.
module sorted_table_binary_search_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  stbs_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output stbs_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stbs_pkg::CNT_W-1:0]    i_cfg_data
);

    logic           push_valid;
    logic           push_ready;
    stbs_pkg::t_cmd push_cmd;
    logic           pop_valid;
    logic           pop;
    stbs_pkg::t_cmd pop_cmd;

    assign o_cfg_ready = 1'b1;

    stbs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    stbs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_cmd    (pop_cmd)
    );

    stbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
